// ----- rtl/bcs_pkg.sv -----
package bcs_pkg;

  localparam int MAX_ROWS = 16;
  localparam int MAX_COLS = 64;
  localparam int ROW_W    = $clog2(MAX_ROWS);
  localparam int COL_W    = $clog2(MAX_COLS);
  localparam int ACOL_W   = 7;
  localparam int AROW_W   = 5;
  localparam int PADDR_W  = 3;
  localparam int PDATA_W  = 32;

  typedef enum logic [1:0] {
    REQ_LOAD = 2'd0,
    REQ_SWAP = 2'd1,
    REQ_READ = 2'd2
  } req_type_t;

  typedef enum logic [1:0] {
    SC_SAME  = 2'd0,
    SC_CROSS = 2'd1,
    SC_LAST  = 2'd2
  } swap_case_t;

  typedef enum logic {
    REG_COLS = 1'b0,
    REG_ROWS = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [1:0]       req_type;
    logic [1:0]       swap_case;
    logic [ROW_W-1:0] first_row;
    logic [COL_W-1:0] first_col;
    logic [ROW_W-1:0] second_row;
    logic [COL_W-1:0] second_col;
    logic             load_bit;
  } req_t;

  typedef struct packed {
    logic read_bit;
    logic swap_done;
    logic bad_position;
  } res_t;

  typedef struct packed {
    logic             en;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             data;
  } wr_t;

endpackage

// ----- rtl/bcs_matrix.sv -----
module bcs_matrix (
  input  logic                                     clk,
  input  logic [bcs_pkg::ROW_W-1:0]                rd_row_a,
  input  logic [bcs_pkg::ROW_W-1:0]                rd_row_b,
  output logic [bcs_pkg::MAX_COLS-1:0]             rd_word_a,
  output logic [bcs_pkg::MAX_COLS-1:0]             rd_word_b,
  input  bcs_pkg::wr_t                             wr_a,
  input  bcs_pkg::wr_t                             wr_b
);
  import bcs_pkg::*;

  logic [MAX_COLS-1:0] bits_r [MAX_ROWS];

  assign rd_word_a = bits_r[rd_row_a];
  assign rd_word_b = bits_r[rd_row_b];

  always_ff @(posedge clk) begin
    if (wr_a.en) begin
      bits_r[wr_a.row][wr_a.col] <= wr_a.data;
    end
    if (wr_b.en) begin
      bits_r[wr_b.row][wr_b.col] <= wr_b.data;
    end
  end

endmodule

// ----- rtl/bcs_eval.sv -----
module bcs_eval (
  input  bcs_pkg::req_t                 req,
  input  logic [bcs_pkg::ACOL_W-1:0]    ncol,
  input  logic [bcs_pkg::AROW_W-1:0]    nrow,
  input  logic [bcs_pkg::MAX_COLS-1:0]  word_a,
  input  logic [bcs_pkg::MAX_COLS-1:0]  word_b,
  output bcs_pkg::res_t                 res,
  output bcs_pkg::wr_t                  wr_a,
  output bcs_pkg::wr_t                  wr_b
);
  import bcs_pkg::*;

  logic              r1_ok, r2_ok, c1_in, c2_in, c1_mid, c2_mid;
  logic [ACOL_W-1:0] ncol_m2;
  logic [COL_W-1:0]  c1, c2, lo, hi, gap, last_col, prev_col;
  logic [1:0]        sum1a, sum2a, sum2b;
  logic              same_ok;

  always_comb begin
    c1       = req.first_col;
    c2       = req.second_col;
    ncol_m2  = ncol - ACOL_W'(2);
    last_col = COL_W'(ncol - ACOL_W'(1));
    prev_col = COL_W'(ncol_m2);
    r1_ok    = {1'b0, req.first_row} < nrow;
    r2_ok    = {1'b0, req.second_row} < nrow;
    c1_in    = {1'b0, c1} < ncol;
    c1_mid   = (c1 != '0) && ({1'b0, c1} <= ncol_m2);
    c2_mid   = (c2 != '0) && ({1'b0, c2} <= ncol_m2);
    c2_in    = c2_mid;
    lo       = (c1 < c2) ? c1 : c2;
    hi       = (c1 < c2) ? c2 : c1;
    gap      = hi - lo;
    sum1a    = {1'b0, word_a[c1 - COL_W'(1)]} + {1'b0, word_a[c1 + COL_W'(1)]};
    sum2a    = {1'b0, word_a[c2 - COL_W'(1)]} + {1'b0, word_a[c2 + COL_W'(1)]};
    sum2b    = {1'b0, word_b[c2 - COL_W'(1)]} + {1'b0, word_b[c2 + COL_W'(1)]};
    if (gap > COL_W'(1)) begin
      same_ok = (sum1a == sum2a);
    end else if (gap == COL_W'(1)) begin
      same_ok = (word_a[lo - COL_W'(1)] == word_a[hi + COL_W'(1)]);
    end else begin
      same_ok = 1'b0;
    end

    res  = '0;
    wr_a = '0;
    wr_b = '0;
    wr_a.row  = req.first_row;
    wr_a.col  = c1;
    wr_b.row  = req.second_row;
    wr_b.col  = c2;

    case (req_type_t'(req.req_type))
      REQ_LOAD: begin
        if (!r1_ok || !c1_in) begin
          res.bad_position = 1'b1;
        end else begin
          wr_a.en   = 1'b1;
          wr_a.data = req.load_bit;
        end
      end
      REQ_READ: begin
        if (!r1_ok || !c1_in) begin
          res.bad_position = 1'b1;
        end else begin
          res.read_bit = word_a[c1];
        end
      end
      REQ_SWAP: begin
        case (swap_case_t'(req.swap_case))
          SC_SAME: begin
            if (!r1_ok || !c1_mid || !c2_in) begin
              res.bad_position = 1'b1;
            end else if (same_ok) begin
              res.swap_done = 1'b1;
              wr_a.en   = 1'b1;
              wr_a.data = word_a[c2];
              wr_b.en   = 1'b1;
              wr_b.row  = req.first_row;
              wr_b.data = word_a[c1];
            end
          end
          SC_CROSS: begin
            if (!r1_ok || !r2_ok || !c1_mid || !c2_in) begin
              res.bad_position = 1'b1;
            end else if (sum1a == sum2b) begin
              res.swap_done = 1'b1;
              wr_a.en   = 1'b1;
              wr_a.data = word_b[c2];
              wr_b.en   = 1'b1;
              wr_b.data = word_a[c1];
            end
          end
          SC_LAST: begin
            if (!r1_ok || !r2_ok) begin
              res.bad_position = 1'b1;
            end else if (word_a[prev_col] == word_b[prev_col]) begin
              res.swap_done = 1'b1;
              wr_a.en   = 1'b1;
              wr_a.col  = last_col;
              wr_a.data = word_b[last_col];
              wr_b.en   = 1'b1;
              wr_b.col  = last_col;
              wr_b.data = word_a[last_col];
            end
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- rtl/binary_chain_transition_preserving_swap.sv -----
// channel | direction | handshake          | payload
// in      | input     | in_valid/in_ready   | req_type swap_case rows cols load_bit
// out     | output    | out_valid/out_ready | read_bit swap_done bad_position
// cfg     | input     | psel/penable/pready | paddr pwdata -> prdata
//
// One item per cycle while out_ready lets results drain; each result passes the
// input register, then the result register. The evaluate stage does the whole
// read-modify-write of the 16x64 flops per item so the next item sees its writes.
// rst_n clears valid flags and config (64 columns, 16 rows); matrix is not reset.
// A stalled result holds; the input stage keeps accepting while it can drain.
module binary_chain_transition_preserving_swap (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [1:0]                     in_req_type,
  input  logic [1:0]                     in_swap_case,
  input  logic [bcs_pkg::ROW_W-1:0]      in_first_row,
  input  logic [bcs_pkg::COL_W-1:0]      in_first_col,
  input  logic [bcs_pkg::ROW_W-1:0]      in_second_row,
  input  logic [bcs_pkg::COL_W-1:0]      in_second_col,
  input  logic                           in_load_bit,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_read_bit,
  output logic                           out_swap_done,
  output logic                           out_bad_position,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [bcs_pkg::PADDR_W-1:0]    paddr,
  input  logic [bcs_pkg::PDATA_W-1:0]    pwdata,
  output logic [bcs_pkg::PDATA_W-1:0]    prdata,
  output logic                           pready
);
  import bcs_pkg::*;

  logic              s1_valid_r, s1_valid_nxt;
  req_t              s1_req_r;
  logic              out_valid_r, out_valid_nxt;
  res_t              out_res_r;
  logic [ACOL_W-1:0] cols_r, cols_nxt, ncol;
  logic [AROW_W-1:0] rows_r, rows_nxt, nrow;
  logic              advance, accept, cfg_wr;
  reg_idx_t          cfg_idx;
  logic [MAX_COLS-1:0] word_a, word_b;
  res_t              res;
  wr_t               wr_a, wr_b, wr_a_g, wr_b_g;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_idx = reg_idx_t'(paddr[2]);

  always_comb begin
    cols_nxt = cols_r;
    rows_nxt = rows_r;
    prdata   = '0;
    case (cfg_idx)
      REG_COLS: begin
        prdata = PDATA_W'(cols_r);
        if (cfg_wr) begin
          cols_nxt = pwdata[ACOL_W-1:0];
        end
      end
      REG_ROWS: begin
        prdata = PDATA_W'(rows_r);
        if (cfg_wr) begin
          rows_nxt = pwdata[AROW_W-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    if (cols_r < ACOL_W'(3)) begin
      ncol = ACOL_W'(3);
    end else if (cols_r > ACOL_W'(MAX_COLS)) begin
      ncol = ACOL_W'(MAX_COLS);
    end else begin
      ncol = cols_r;
    end
    if (rows_r < AROW_W'(1)) begin
      nrow = AROW_W'(1);
    end else if (rows_r > AROW_W'(MAX_ROWS)) begin
      nrow = AROW_W'(MAX_ROWS);
    end else begin
      nrow = rows_r;
    end
  end

  assign advance       = s1_valid_r & (~out_valid_r | out_ready);
  assign in_ready      = ~s1_valid_r | advance;
  assign accept        = in_valid & in_ready;
  assign s1_valid_nxt  = accept | (s1_valid_r & ~advance);
  assign out_valid_nxt = advance | (out_valid_r & ~out_ready);

  always_comb begin
    wr_a_g    = wr_a;
    wr_b_g    = wr_b;
    wr_a_g.en = wr_a.en & advance;
    wr_b_g.en = wr_b.en & advance;
  end

  bcs_matrix u_matrix (
    .clk       (clk),
    .rd_row_a  (s1_req_r.first_row),
    .rd_row_b  (s1_req_r.second_row),
    .rd_word_a (word_a),
    .rd_word_b (word_b),
    .wr_a      (wr_a_g),
    .wr_b      (wr_b_g)
  );

  bcs_eval u_eval (
    .req    (s1_req_r),
    .ncol   (ncol),
    .nrow   (nrow),
    .word_a (word_a),
    .word_b (word_b),
    .res    (res),
    .wr_a   (wr_a),
    .wr_b   (wr_b)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      cols_r      <= ACOL_W'(MAX_COLS);
      rows_r      <= AROW_W'(MAX_ROWS);
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      cols_r      <= cols_nxt;
      rows_r      <= rows_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_req_r <= '{req_type:   in_req_type,
                    swap_case:  in_swap_case,
                    first_row:  in_first_row,
                    first_col:  in_first_col,
                    second_row: in_second_row,
                    second_col: in_second_col,
                    load_bit:   in_load_bit};
    end
    if (advance) begin
      out_res_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_read_bit     = out_res_r.read_bit;
  assign out_swap_done    = out_res_r.swap_done;
  assign out_bad_position = out_res_r.bad_position;

endmodule
